>>> rtl/cssavm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssavm_pkg
// Shared constants, codes and helpers of the attribute value matcher.
// ----------------------------------------------------------------------------
package cssavm_pkg;

   // longest target the window and counters support (8 to 32)
   localparam int MAX_TARGET = 32;

   // target storage is always four 64-bit words
   localparam int TGT_WORDS  = 4;
   localparam int WORD_W     = 64;
   localparam int TGT_BYTES  = TGT_WORDS * WORD_W / 8;
   localparam int TGT_BITS   = TGT_BYTES * 8;
   localparam int TGT_IDX_W  = $clog2(TGT_BYTES);
   localparam int WIN_BITS   = MAX_TARGET * 8;

   localparam int CNT_W      = 6;
   localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_TARGET + 1);
   localparam logic [CNT_W-1:0] TGT_LIMIT = CNT_W'(MAX_TARGET);
   localparam logic [CNT_W-1:0] TGT_CAP   = CNT_W'(TGT_BYTES);

   // operators
   localparam logic [2:0] OP_PRESENCE = 3'd0;
   localparam logic [2:0] OP_EQUAL    = 3'd1;
   localparam logic [2:0] OP_TOKEN    = 3'd2;
   localparam logic [2:0] OP_HYPHEN   = 3'd3;
   localparam logic [2:0] OP_PREFIX   = 3'd4;
   localparam logic [2:0] OP_SUFFIX   = 3'd5;
   localparam logic [2:0] OP_SUBSTR   = 3'd6;
   localparam logic [2:0] OP_NEVER    = 3'd7;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_OP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TGT_LEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TGT_W0   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TGT_W1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TGT_W2   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TGT_W3   = 3'd5;

   // characters
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_FF     = 8'h0C;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_CR) || (c == CH_FF);
   endfunction

   function automatic logic [7:0] tgt_byte(input logic [TGT_BITS-1:0] v,
                                           input logic [TGT_IDX_W-1:0] i);
      return v[i*8 +: 8];
   endfunction

endpackage

>>> rtl/css_attribute_value_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_attribute_value_matcher_unit
// Streams an attribute value one byte per beat and returns one match bit
// for the configured selector operator on the beat that ends the value.
//
//   channel | dir | handshake          | payload
//   req     | in  | tvalid/tready      | tdata: value_byte; tuser: byte_valid,
//           |     |                    | value_present; tlast: value_last
//   rsp     | out | tvalid/tready      | tdata: matched
//   csr     | in  | csr_we             | csr_index, csr_wdata
//
// One beat per cycle unless stalled; the result follows in the next cycle.
// All flags and the parallel window compare update in the accepting cycle.
// Reset clears the CSRs and value state at once; no clearing pass.
// req_tready drops only while a result is held and rsp_tready is low.
// ----------------------------------------------------------------------------
module css_attribute_value_matcher_unit import cssavm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] value_byte
   input  logic [1:0]           req_tuser,   // [0] byte_valid, [1] value_present
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [0] matched, [7:1] zero
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   // configuration
   logic [2:0]                      op_ff;
   logic [CNT_W-1:0]                tl_ff;
   logic [TGT_WORDS-1:0][WORD_W-1:0] tw_ff;
   logic [TGT_BITS-1:0]             tgt_vec;

   // value state
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WIN_BITS-1:0] win_ff, win_in;
   logic                pref_ff, pref_in;
   logic                hyph_ff, hyph_in;
   logic                sub_ff, sub_in;
   logic [CNT_W-1:0]    tp_ff, tp_in;
   logic                tok_ok_ff, tok_ok_in;
   logic                tokf_ff, tokf_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_match_ff, rsp_match_in;

   logic       acc, take, end_item, is_sp, tail, tgt_ws, eq, dec;
   logic [7:0] b;
   logic [CNT_W-1:0] p, tp;

   assign tgt_vec = tw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_PRESENCE;
         tl_ff <= '0;
         tw_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MATCH_OP: op_ff    <= csr_wdata[2:0];
            REG_TGT_LEN:  tl_ff    <= csr_wdata[CNT_W-1:0];
            REG_TGT_W0:   tw_ff[0] <= csr_wdata;
            REG_TGT_W1:   tw_ff[1] <= csr_wdata;
            REG_TGT_W2:   tw_ff[2] <= csr_wdata;
            REG_TGT_W3:   tw_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign take       = req_tuser[1] && req_tuser[0];
   assign end_item   = !req_tuser[1] || req_tlast;
   assign is_sp      = is_space(b);
   assign p          = cnt_ff;
   assign tp         = tp_ff;

   // state after this beat's byte, before the end-of-value clear
   logic [CNT_W-1:0]    cnt_eff, tp_eff;
   logic [WIN_BITS-1:0] win_eff;
   logic pref_eff, hyph_eff, sub_eff, tok_ok_eff, tokf_eff;

   always_comb begin
      cnt_eff    = cnt_ff;
      win_eff    = win_ff;
      pref_eff   = pref_ff;
      hyph_eff   = hyph_ff;
      tp_eff     = tp_ff;
      tok_ok_eff = tok_ok_ff;
      tokf_eff   = tokf_ff;
      if (take) begin
         cnt_eff = (p < CNT_SAT) ? p + 1'b1 : CNT_SAT;
         win_eff = {win_ff[WIN_BITS-9:0], b};
         if ((p < tl_ff) && (p < TGT_CAP) &&
             (b != tgt_byte(tgt_vec, p[TGT_IDX_W-1:0]))) begin
            pref_eff = 1'b0;
         end
         if ((p == tl_ff) && (b == CH_HYPHEN)) begin
            hyph_eff = 1'b1;
         end
         if (is_sp) begin
            if ((tp != '0) && (tp == tl_ff) && tok_ok_ff) begin
               tokf_eff = 1'b1;
            end
            tp_eff     = '0;
            tok_ok_eff = 1'b1;
         end else begin
            if ((tp < tl_ff) && (tp < TGT_CAP) &&
                (b != tgt_byte(tgt_vec, tp[TGT_IDX_W-1:0]))) begin
               tok_ok_eff = 1'b0;
            end
            tp_eff = (tp < CNT_SAT) ? tp + 1'b1 : CNT_SAT;
         end
      end
   end

   cssavm_tail_match u_tail (
      .win     (win_eff),
      .tgt     (tgt_vec),
      .tgt_len (tl_ff),
      .count   (cnt_eff),
      .hit     (tail)
   );

   assign sub_eff = sub_ff || (take && tail);

   always_comb begin
      tgt_ws = 1'b0;
      for (int i = 0; i < TGT_BYTES; i++) begin
         if ((CNT_W'(i) < tl_ff) && is_space(tgt_vec[i*8 +: 8])) begin
            tgt_ws = 1'b1;
         end
      end
   end

   assign eq = pref_eff && (cnt_eff == tl_ff);

   always_comb begin
      unique case (op_ff)
         OP_PRESENCE: dec = 1'b1;
         OP_EQUAL:    dec = eq;
         OP_TOKEN:    dec = (tl_ff != '0) && !tgt_ws &&
                            (tokf_eff || ((tp_eff != '0) && (tp_eff == tl_ff) && tok_ok_eff));
         OP_HYPHEN:   dec = eq || ((cnt_eff > tl_ff) && pref_eff && hyph_eff);
         OP_PREFIX:   dec = (tl_ff != '0) && (cnt_eff >= tl_ff) && pref_eff;
         OP_SUFFIX:   dec = tail;
         OP_SUBSTR:   dec = (tl_ff != '0) && sub_eff;
         OP_NEVER:    dec = 1'b0;
         default:     dec = 1'b0;
      endcase
      if ((op_ff != OP_PRESENCE) && (tl_ff > TGT_LIMIT)) begin
         dec = 1'b0;
      end
      if (!req_tuser[1]) begin
         dec = 1'b0;
      end
   end

   always_comb begin
      cnt_in    = cnt_ff;
      win_in    = win_ff;
      pref_in   = pref_ff;
      hyph_in   = hyph_ff;
      sub_in    = sub_ff;
      tp_in     = tp_ff;
      tok_ok_in = tok_ok_ff;
      tokf_in   = tokf_ff;
      if (acc) begin
         win_in = win_eff;
         if (end_item) begin
            // back to the start-of-value state
            cnt_in    = '0;
            pref_in   = 1'b1;
            hyph_in   = 1'b0;
            sub_in    = 1'b0;
            tp_in     = '0;
            tok_ok_in = 1'b1;
            tokf_in   = 1'b0;
         end else begin
            cnt_in    = cnt_eff;
            pref_in   = pref_eff;
            hyph_in   = hyph_eff;
            sub_in    = sub_eff;
            tp_in     = tp_eff;
            tok_ok_in = tok_ok_eff;
            tokf_in   = tokf_eff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_match_in = rsp_match_ff;
      if (acc && end_item) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pref_ff      <= 1'b1;
         hyph_ff      <= 1'b0;
         sub_ff       <= 1'b0;
         tp_ff        <= '0;
         tok_ok_ff    <= 1'b1;
         tokf_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pref_ff      <= pref_in;
         hyph_ff      <= hyph_in;
         sub_ff       <= sub_in;
         tp_ff        <= tp_in;
         tok_ok_ff    <= tok_ok_in;
         tokf_ff      <= tokf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window bytes are only read below the byte count, so no reset
   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_match_ff};

`ifndef SYNTHESIS
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (acc && !req_tuser[1]) |=> (rsp_tvalid && !rsp_tdata[0]))
      else $error("absent attribute did not give a zero result");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (acc && end_item) |=> ((cnt_ff == '0) && (tp_ff == '0) && !sub_ff && !tokf_ff))
      else $error("value state not cleared after end of value");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_SAT) && (tp_ff <= cnt_ff))
      else $error("byte or token count out of range");

   a_never_zero: assert property (@(posedge clock) disable iff (reset)
      (acc && end_item && (op_ff == OP_NEVER)) |=> !rsp_match_ff)
      else $error("operator never gave a match");
`endif

endmodule

>>> rtl/cssavm_tail_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssavm_tail_match
// Compares the newest tgt_len bytes of the window against the target.
// ----------------------------------------------------------------------------
module cssavm_tail_match import cssavm_pkg::*; (
   input  logic [WIN_BITS-1:0] win,     // newest byte in the low bits
   input  logic [TGT_BITS-1:0] tgt,     // target byte 0 in the low bits
   input  logic [CNT_W-1:0]    tgt_len,
   input  logic [CNT_W-1:0]    count,
   output logic                hit
);

   logic [TGT_BITS-1:0] rev;
   logic [TGT_BITS-1:0] aligned;
   logic [CNT_W-1:0]    sh;
   logic [MAX_TARGET-1:0] ok;

   // reverse byte order so the last target byte meets the newest window byte
   always_comb begin
      for (int k = 0; k < TGT_BYTES; k++) begin
         rev[k*8 +: 8] = tgt[(TGT_BYTES-1-k)*8 +: 8];
      end
   end

   assign sh      = TGT_CAP - tgt_len;
   assign aligned = rev >> {sh, 3'b000};

   always_comb begin
      for (int j = 0; j < MAX_TARGET; j++) begin
         ok[j] = (CNT_W'(j) >= tgt_len) || (win[j*8 +: 8] == aligned[j*8 +: 8]);
      end
   end

   assign hit = (tgt_len != '0) && (tgt_len <= TGT_LIMIT) && (count >= tgt_len) && (&ok);

endmodule
